FILE: hdl/etk_pkg.sv
// Shared types and constants for the edge token run expander.
`timescale 1ns / 1ps
package etk_pkg;

  localparam int ETK_BYTE_W = 8;
  localparam int ETK_RUN_W = 26;
  localparam int ETK_CNT_W = 32;
  localparam int ETK_TDATA_W = 40;
  localparam int unsigned ETK_UPB_DEF = 127;
  localparam logic [7:0] ETK_MARKER_RST = 8'd128;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ERR,
    KIND_RUN
  } etk_kind_e;

  typedef struct packed {
    etk_kind_e kind;
    logic level;
    logic last;
    logic [ETK_BYTE_W-1:0] data;
  } etk_item_t;

  // width of the unreduced remainder sum: four bytes times (divisor - 1)
  function automatic int etk_rsum_w(int unsigned upb);
    return 10 + $clog2(upb + 1);
  endfunction

endpackage

FILE: hdl/etk_token_parser.sv
// Token parser: phase tracking and per-byte quotient/remainder accumulation.
`timescale 1ns / 1ps
module etk_token_parser import etk_pkg::*; #(
  parameter int unsigned UNITS_PER_BYTE = ETK_UPB_DEF,
  localparam int RSUM_W = etk_rsum_w(UNITS_PER_BYTE)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [ETK_BYTE_W-1:0] byte_i,
  input  logic                  last_i,
  input  logic [ETK_BYTE_W-1:0] marker_i,
  output logic                  emit_o,
  output etk_item_t             item_o,
  output logic [RSUM_W-1:0]     rsum_o,
  output logic [ETK_CNT_W-1:0]  qsum_o
);

  localparam int DW = $clog2(UNITS_PER_BYTE + 1);
  localparam longint unsigned D = longint'(UNITS_PER_BYTE);
  localparam logic [ETK_CNT_W-1:0] Q0 = ETK_CNT_W'(64'd1 / D);
  localparam logic [ETK_CNT_W-1:0] Q1 = ETK_CNT_W'(64'd256 / D);
  localparam logic [ETK_CNT_W-1:0] Q2 = ETK_CNT_W'(64'd65536 / D);
  localparam logic [ETK_CNT_W-1:0] Q3 = ETK_CNT_W'(64'd16777216 / D);
  localparam logic [DW-1:0] R0 = DW'(64'd1 % D);
  localparam logic [DW-1:0] R1 = DW'(64'd256 % D);
  localparam logic [DW-1:0] R2 = DW'(64'd65536 % D);
  localparam logic [DW-1:0] R3 = DW'(64'd16777216 % D);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEVEL,
    PH_CNT0,
    PH_CNT1,
    PH_CNT2,
    PH_CNT3
  } phase_e;

  phase_e phase_q, phase_d;
  logic level_q, level_d;
  logic nz_q, nz_d;
  logic [RSUM_W-1:0] racc_q, racc_d;
  logic [ETK_CNT_W-1:0] qacc_q, qacc_d;

  logic [DW-1:0] rk;
  logic [ETK_CNT_W-1:0] qk;
  logic [RSUM_W-1:0] rsum_new;
  logic [ETK_CNT_W-1:0] qsum_new;
  logic [ETK_CNT_W+ETK_BYTE_W-1:0] qprod;

  always_comb begin
    case (phase_q)
      PH_CNT0: begin rk = R0; qk = Q0; end
      PH_CNT1: begin rk = R1; qk = Q1; end
      PH_CNT2: begin rk = R2; qk = Q2; end
      PH_CNT3: begin rk = R3; qk = Q3; end
      default: begin rk = '0; qk = '0; end
    endcase
  end

  assign qprod = (ETK_CNT_W+ETK_BYTE_W)'(byte_i) * (ETK_CNT_W+ETK_BYTE_W)'(qk);
  assign rsum_new = racc_q + RSUM_W'(RSUM_W'(byte_i) * RSUM_W'(rk));
  assign qsum_new = qacc_q + qprod[ETK_CNT_W-1:0];

  assign rsum_o = rsum_new;
  assign qsum_o = qsum_new;

  always_comb begin
    phase_d = phase_q;
    level_d = level_q;
    nz_d = nz_q;
    racc_d = racc_q;
    qacc_d = qacc_q;
    emit_o = 1'b0;
    item_o.kind = KIND_ERR;
    item_o.level = level_q;
    item_o.last = 1'b1;
    item_o.data = '0;
    case (phase_q)
      PH_LEVEL: begin
        level_d = (byte_i != '0);
        nz_d = 1'b0;
        racc_d = '0;
        qacc_d = '0;
        if (last_i) begin
          emit_o = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_CNT0;
        end
      end
      PH_CNT0, PH_CNT1, PH_CNT2: begin
        nz_d = nz_q | (byte_i != '0);
        racc_d = rsum_new;
        qacc_d = qsum_new;
        if (last_i) begin
          emit_o = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          phase_d = phase_e'(phase_q + 3'd1);
        end
      end
      PH_CNT3: begin
        phase_d = PH_IDLE;
        item_o.kind = KIND_RUN;
        item_o.last = last_i;
        emit_o = nz_q | (byte_i != '0);
      end
      default: begin
        if (byte_i == marker_i) begin
          if (last_i) begin
            emit_o = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_LEVEL;
          end
        end else begin
          phase_d = PH_IDLE;
          emit_o = 1'b1;
          item_o.kind = KIND_PASS;
          item_o.last = last_i;
          item_o.data = byte_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      level_q <= 1'b0;
      nz_q <= 1'b0;
      racc_q <= '0;
      qacc_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      level_q <= level_d;
      nz_q <= nz_d;
      racc_q <= racc_d;
      qacc_q <= qacc_d;
    end
  end

endmodule

FILE: hdl/etk_run_divider.sv
// Run divider: final quotient/remainder by reciprocal multiply and output register.
`timescale 1ns / 1ps
module etk_run_divider import etk_pkg::*; #(
  parameter int unsigned UNITS_PER_BYTE = ETK_UPB_DEF,
  localparam int RSUM_W = etk_rsum_w(UNITS_PER_BYTE)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  etk_item_t             item_i,
  input  logic [RSUM_W-1:0]     rsum_i,
  input  logic [ETK_CNT_W-1:0]  qsum_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ETK_BYTE_W-1:0] out_byte_o,
  output logic [ETK_RUN_W-1:0]  zero_run_o,
  output logic                  split_error_o,
  output logic                  stream_end_o
);

  localparam int DW = $clog2(UNITS_PER_BYTE + 1);
  localparam int SH = RSUM_W + DW;
  localparam int MW = SH + 1;
  localparam int PW = RSUM_W + MW;
  localparam int BW = RSUM_W + DW;
  localparam longint unsigned MULT =
      ((64'd1 << SH) + longint'(UNITS_PER_BYTE) - 64'd1) / longint'(UNITS_PER_BYTE);
  localparam logic [MW-1:0] MULT_C = MW'(MULT);
  localparam logic [DW-1:0] UPB_C = DW'(UNITS_PER_BYTE);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  etk_item_t item1_q, item2_q;
  logic [RSUM_W-1:0] rsum1_q;
  logic [ETK_CNT_W-1:0] qsum1_q;
  logic [RSUM_W-1:0] x2_q, qq2_q;
  logic [ETK_CNT_W-1:0] qbase2_q;

  logic [ETK_BYTE_W-1:0] byte3_q, byte3_d;
  logic [ETK_RUN_W-1:0] run3_q, run3_d;
  logic err3_q, last3_q;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: n - 1 split into base quotient and small remainder sum
  logic rzero;
  logic [RSUM_W-1:0] x1;
  logic [ETK_CNT_W-1:0] qbase1;
  logic [PW-1:0] prod1;

  assign rzero = (rsum1_q == '0);
  assign x1 = rzero ? RSUM_W'(UNITS_PER_BYTE - 1) : rsum1_q - RSUM_W'(1);
  assign qbase1 = rzero ? qsum1_q - ETK_CNT_W'(1) : qsum1_q;
  assign prod1 = PW'(x1) * PW'(MULT_C);

  // stage 2: remainder recovery, sign and saturation
  logic [BW-1:0] back2, rem2;
  logic [ETK_BYTE_W-1:0] r2;
  logic [ETK_CNT_W:0] qfull2;

  assign back2 = BW'(qq2_q) * BW'(UPB_C);
  assign rem2 = BW'(x2_q) - back2;
  assign r2 = rem2[ETK_BYTE_W-1:0] + ETK_BYTE_W'(1);
  assign qfull2 = {1'b0, qbase2_q} + (ETK_CNT_W+1)'(qq2_q);

  always_comb begin
    byte3_d = item2_q.data;
    run3_d = '0;
    if (item2_q.kind == KIND_RUN) begin
      byte3_d = item2_q.level ? r2 : ETK_BYTE_W'(0) - r2;
      run3_d = (|qfull2[ETK_CNT_W:ETK_RUN_W]) ? '1 : qfull2[ETK_RUN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      item1_q <= item_i;
      rsum1_q <= rsum_i;
      qsum1_q <= qsum_i;
    end
    if (rdy2) begin
      item2_q <= item1_q;
      x2_q <= x1;
      qq2_q <= prod1[SH +: RSUM_W];
      qbase2_q <= qbase1;
    end
    if (rdy3) begin
      byte3_q <= byte3_d;
      run3_q <= run3_d;
      err3_q <= (item2_q.kind == KIND_ERR);
      last3_q <= item2_q.last;
    end
  end

  assign out_valid_o = v3_q;
  assign out_byte_o = byte3_q;
  assign zero_run_o = run3_q;
  assign split_error_o = err3_q;
  assign stream_end_o = last3_q;

endmodule

FILE: hdl/edge_token_run_expander.sv
// Top level of the edge token run expander: input register, parser, divider.
//
//   channel  dir  handshake             payload
//   s        in   s_tvalid_i/s_tready_o  s_tdata_i = in_byte, s_tlast_i = in_last
//   m        out  m_tvalid_o/m_tready_i  m_tdata_o = out_byte, zero_run;
//                                        m_tuser_o = split_error, m_tlast_o = stream_end
//   cfg      in   cfg_wr_en_i            cfg_wr_data_i = marker_code
//
// One byte per cycle while m_tready_i is high; a result leaves after its last input byte
// passes the input register, parser, reciprocal multiply and remainder/output register.
// Marker and token bytes that give no result leave a bubble.
// Reset clears all valid flags and the token phase; marker_code returns to 128.
// m_tready_i low stalls the register chain; up to four requests are held.
`timescale 1ns / 1ps
module edge_token_run_expander import etk_pkg::*; #(
  parameter int unsigned UNITS_PER_BYTE = ETK_UPB_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [7:0]             s_tdata_i,     // [7:0] in_byte
  input  logic                   s_tlast_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [ETK_TDATA_W-1:0] m_tdata_o,     // [7:0] out_byte, [33:8] zero_run, zero pad
  output logic [0:0]             m_tuser_o,     // [0] split_error
  output logic                   m_tlast_o,
  input  logic                   cfg_wr_en_i,
  input  logic [7:0]             cfg_wr_data_i
);

  localparam int RSUM_W = etk_rsum_w(UNITS_PER_BYTE);

  logic [ETK_BYTE_W-1:0] marker_q;
  logic v0_q;
  logic [ETK_BYTE_W-1:0] byte0_q;
  logic last0_q;
  logic div_ready, take, emit;
  etk_item_t item;
  logic [RSUM_W-1:0] rsum;
  logic [ETK_CNT_W-1:0] qsum;
  logic [ETK_BYTE_W-1:0] out_byte;
  logic [ETK_RUN_W-1:0] zero_run;
  logic split_error;

  assign take = v0_q && div_ready;
  assign s_tready_o = !v0_q || div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= ETK_MARKER_RST;
      v0_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) marker_q <= cfg_wr_data_i;
      if (s_tready_o) v0_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o) begin
      byte0_q <= s_tdata_i;
      last0_q <= s_tlast_i;
    end
  end

  etk_token_parser #(
    .UNITS_PER_BYTE(UNITS_PER_BYTE)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .byte_i   (byte0_q),
    .last_i   (last0_q),
    .marker_i (marker_q),
    .emit_o   (emit),
    .item_o   (item),
    .rsum_o   (rsum),
    .qsum_o   (qsum)
  );

  etk_run_divider #(
    .UNITS_PER_BYTE(UNITS_PER_BYTE)
  ) u_divider (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (v0_q && emit),
    .in_ready_o    (div_ready),
    .item_i        (item),
    .rsum_i        (rsum),
    .qsum_i        (qsum),
    .out_valid_o   (m_tvalid_o),
    .out_ready_i   (m_tready_i),
    .out_byte_o    (out_byte),
    .zero_run_o    (zero_run),
    .split_error_o (split_error),
    .stream_end_o  (m_tlast_o)
  );

  assign m_tdata_o = {(ETK_TDATA_W-ETK_RUN_W-ETK_BYTE_W)'(0), zero_run, out_byte};
  assign m_tuser_o = split_error;

`ifndef SYNTHESIS
  a_err_ends_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |-> m_tlast_o)
    else $error("split error without stream end");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |-> m_tdata_o == '0)
    else $error("split error carries data");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> v0_q && !div_ready)
    else $error("input stalled without a held request");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for edge_token_run_expander: directed table, random token streams.
`timescale 1ns / 1ps
module tb_top;
  import etk_pkg::*;

  localparam int unsigned UPB      = ETK_UPB_DEF;
  localparam longint unsigned RUN_MAX = (64'd1 << ETK_RUN_W) - 1;
  localparam int unsigned LIMIT    = 400000;
  localparam int unsigned DRAIN    = 16;
  localparam int unsigned HOLD_CYC = 300;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEVEL, PH_CNT0, PH_CNT1, PH_CNT2, PH_CNT3
  } tok_phase_e;

  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_RES} row_mode_e;

  typedef struct packed {
    logic [ETK_BYTE_W-1:0] lead;
    logic [ETK_RUN_W-1:0]  run;
    logic                  err;
    logic                  fin;
  } run_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    row_mode_e  mode;
    run_res_t   res;
  } dir_row_t;

  localparam run_res_t NO_RES  = '0;
  localparam run_res_t SPLIT   = '{8'h00, 26'd0, 1'b1, 1'b1};

  // reset marker 0x80
  localparam int N_DIR = 27;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{8'h00, 1'b0, ROW_PRED, NO_RES},
    '{8'hFF, 1'b1, ROW_RES,  '{8'hFF, 26'd0, 1'b0, 1'b1}},
    // count 1, high level
    '{8'h80, 1'b0, ROW_NONE, NO_RES},
    '{8'h01, 1'b0, ROW_NONE, NO_RES},
    '{8'h01, 1'b0, ROW_NONE, NO_RES},
    '{8'h00, 1'b0, ROW_NONE, NO_RES},
    '{8'h00, 1'b0, ROW_NONE, NO_RES},
    '{8'h00, 1'b0, ROW_RES,  '{8'h01, 26'd0, 1'b0, 1'b0}},
    // count 0xFFFFFFFF, low level: remainder 15, longest run
    '{8'h80, 1'b0, ROW_NONE, NO_RES},
    '{8'h00, 1'b0, ROW_NONE, NO_RES},
    '{8'hFF, 1'b0, ROW_NONE, NO_RES},
    '{8'hFF, 1'b0, ROW_NONE, NO_RES},
    '{8'hFF, 1'b0, ROW_NONE, NO_RES},
    '{8'hFF, 1'b0, ROW_RES,  '{8'hF1, 26'd33818640, 1'b0, 1'b0}},
    // zero count carrying stream end: nothing comes out
    '{8'h80, 1'b0, ROW_NONE, NO_RES},
    '{8'h05, 1'b0, ROW_NONE, NO_RES},
    '{8'h00, 1'b0, ROW_NONE, NO_RES},
    '{8'h00, 1'b0, ROW_NONE, NO_RES},
    '{8'h00, 1'b0, ROW_NONE, NO_RES},
    '{8'h00, 1'b1, ROW_NONE, NO_RES},
    // stream ends on the marker, on the level, inside the count
    '{8'h80, 1'b1, ROW_RES,  SPLIT},
    '{8'h80, 1'b0, ROW_NONE, NO_RES},
    '{8'h00, 1'b1, ROW_RES,  SPLIT},
    '{8'h80, 1'b0, ROW_NONE, NO_RES},
    '{8'h01, 1'b0, ROW_NONE, NO_RES},
    '{8'h2A, 1'b0, ROW_NONE, NO_RES},
    '{8'h7F, 1'b1, ROW_RES,  SPLIT}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid_i = 1'b0;
  logic                   s_tready_o;
  logic [7:0]             s_tdata_i = 8'h00;
  logic                   s_tlast_i = 1'b0;
  logic                   m_tvalid_o;
  logic                   m_tready_i = 1'b0;
  logic [ETK_TDATA_W-1:0] m_tdata_o;
  logic [0:0]             m_tuser_o;
  logic                   m_tlast_o;
  logic                   cfg_wr_en_i = 1'b0;
  logic [7:0]             cfg_wr_data_i = 8'h00;

  // tag of the request on the bus: table expectation or predictor
  row_mode_e req_mode = ROW_PRED;
  run_res_t  req_res = NO_RES;

  // predictor state
  tok_phase_e  tok_ph = PH_IDLE;
  logic        tok_lvl = 1'b0;
  logic [31:0] tok_cnt = '0;
  logic [7:0]  tok_marker = ETK_MARKER_RST;

  run_res_t    lead_q[$];
  int unsigned n_sent = 0, n_out = 0, n_split = 0, n_runs = 0, n_fail = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0, hold_go = 1'b0, hold_done = 1'b0;

  edge_token_run_expander dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid_i),
    .s_tready_o    (s_tready_o),
    .s_tdata_i     (s_tdata_i),
    .s_tlast_i     (s_tlast_i),
    .m_tvalid_o    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .m_tdata_o     (m_tdata_o),
    .m_tuser_o     (m_tuser_o),
    .m_tlast_o     (m_tlast_o),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit tok_step(input logic [7:0] b, input logic last, output run_res_t res);
    longint unsigned n, q, r;
    res = '0;
    case (tok_ph)
      PH_LEVEL: begin
        tok_lvl = (b != 8'h00);
        tok_cnt = '0;
        if (last) begin
          tok_ph = PH_IDLE;
          res = SPLIT;
          return 1'b1;
        end
        tok_ph = PH_CNT0;
        return 1'b0;
      end
      PH_CNT0, PH_CNT1, PH_CNT2, PH_CNT3: begin
        tok_cnt |= {24'd0, b} << (8 * (tok_ph - PH_CNT0));
        if (tok_ph != PH_CNT3) begin
          if (last) begin
            tok_ph = PH_IDLE;
            res = SPLIT;
            return 1'b1;
          end
          tok_ph = tok_phase_e'(tok_ph + 1);
          return 1'b0;
        end
        tok_ph = PH_IDLE;
        if (tok_cnt == 0) return 1'b0;
        n = tok_cnt;
        q = (n - 1) / UPB;
        r = n - q * UPB;
        if (q > RUN_MAX) q = RUN_MAX;
        res.lead = tok_lvl ? r[7:0] : 8'(64'd0 - r);
        res.run = q[ETK_RUN_W-1:0];
        res.fin = last;
        return 1'b1;
      end
      default: begin
        if (b == tok_marker) begin
          if (last) begin
            tok_ph = PH_IDLE;
            res = SPLIT;
            return 1'b1;
          end
          tok_ph = PH_LEVEL;
          return 1'b0;
        end
        tok_ph = PH_IDLE;
        res.lead = b;
        res.fin = last;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : mon
    run_res_t pr, got, want;
    bit has;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        has = tok_step(s_tdata_i, s_tlast_i, pr);
        case (req_mode)
          ROW_RES:  lead_q.push_back(req_res);
          ROW_NONE: ;
          default:  if (has) lead_q.push_back(pr);
        endcase
      end
      if (cfg_wr_en_i) tok_marker = cfg_wr_data_i;
      if (m_tvalid_o && m_tready_i) begin
        got = '{m_tdata_o[7:0], m_tdata_o[33:8], m_tuser_o[0], m_tlast_o};
        n_out++;
        if (got.err) n_split++;
        if (got.run != 0) n_runs++;
        if (lead_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result lead %h run %0d err %b end %b",
                   $time, got.lead, got.run, got.err, got.fin);
        end else begin
          want = lead_q.pop_front();
          if (got !== want || m_tdata_o[ETK_TDATA_W-1:34] !== '0) begin
            n_fail++;
            $display("%0t: mismatch exp lead %h run %0d err %b end %b, got lead %h run %0d err %b end %b pad %h",
                     $time, want.lead, want.run, want.err, want.fin,
                     got.lead, got.run, got.err, got.fin, m_tdata_o[ETK_TDATA_W-1:34]);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : sink
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        m_tready_i <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_done = 1'b1;
        m_tready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_tready_i <= 1'b1;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last,
                          input row_mode_e mode = ROW_PRED, input run_res_t res = NO_RES);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= b;
    s_tlast_i <= last;
    req_mode <= mode;
    req_res <= res;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    n_sent++;
  endtask

  // idle the input, let every expected result and any bubble drain
  task automatic settle();
    s_tvalid_i <= 1'b0;
    while (lead_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_marker(input logic [7:0] v);
    settle();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic send_token();
    logic [31:0] cnt;
    logic [7:0]  tok [6];
    int unsigned brk;
    logic        last;
    case ($urandom_range(0, 5))
      0:       cnt = '0;
      1:       cnt = $urandom_range(1, 381);
      2:       cnt = $urandom;
      3:       cnt = 127 * $urandom_range(1, 5000) + $urandom_range(0, 1);
      4:       cnt = 32'hFFFF_FFFF - $urandom_range(0, 300);
      default: cnt = $urandom_range(1, 100000);
    endcase
    tok[0] = tok_marker;
    tok[1] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
    for (int i = 0; i < 4; i++) tok[2+i] = cnt[8*i +: 8];
    brk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : 6;
    for (int i = 0; i < 6; i++) begin
      last = (i == brk) || (i == 5 && $urandom_range(0, 9) == 0);
      put_byte(tok[i], last);
      if (last) break;
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop;
    stop = n_sent + count;
    while (n_sent < stop) begin
      if ($urandom_range(0, 9) < 6) send_token();
      else put_byte(8'($urandom), $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin : stim
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++)
      put_byte(DIR_TAB[i].b, DIR_TAB[i].last, DIR_TAB[i].mode, DIR_TAB[i].res);
    settle();

    hold_go = 1'b1;
    run_random(350);
    set_marker(8'h00);
    run_random(300);
    set_marker(8'hFF);
    run_random(300);
    set_marker(8'($urandom));
    run_random(200);
    set_marker(ETK_MARKER_RST);
    calm = 1'b1;
    run_random(150);
    settle();

    $display("summary: %0d bytes in, %0d results out, %0d with zero runs, %0d split errors",
             n_sent, n_out, n_runs, n_split);
    $display("summary: markers 0x80, 0x00, 0xFF and random; one %0d-cycle output stall",
             HOLD_CYC);
    if (n_fail == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/etk_pkg.sv
hdl/etk_token_parser.sv
hdl/etk_run_divider.sv
hdl/edge_token_run_expander.sv
bench/tb_top.sv
